// ===== hw/rtl/conv2d_5x5_valid_accumulate_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CONV2D_5X5_VALID_ACCUMULATE_MACROS_SVH
`define CONV2D_5X5_VALID_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define C2D_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("c2d check failed");

// Next-cycle implication, active during reset too.
`define C2D_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("c2d check failed");

`endif

// ===== hw/rtl/c2d_pkg.sv =====
// Package: shared types and constants of the 5x5 convolution block.
`timescale 1ns / 1ps
`default_nettype none
package c2d_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int KSIZE = 5;
  localparam int KTAPS = 25;
  localparam int LINES = 4;
  localparam int QDEPTH = 8;
  localparam logic signed [39:0] VAL_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] VAL_MIN = {1'b1, {39{1'b0}}};

  typedef enum logic [1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_OUT_WIDTH  = 2'd1,
    REG_OUT_HEIGHT = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_LOAD_WEIGHT = 1'b0,
    OP_PIXEL       = 1'b1
  } opcode_t;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic [10:0] in_width;
    logic [9:0]  out_width;
    logic [9:0]  out_height;
  } cfg_t;

  typedef struct packed {
    logic              last;
    logic [9:0]        row;
    logic [9:0]        col;
    logic signed [39:0] prior;
  } meta_t;

  typedef struct packed {
    logic  valid;
    meta_t meta;
  } mac_req_t;

  typedef struct packed {
    logic signed [39:0] value;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               last;
  } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/c2d_front.sv =====
// Front end: raster counters, line memory banks, 5x5 window and kernel weights.
`timescale 1ns / 1ps
`default_nettype none
module c2d_front import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire logic         accept,
  input  wire logic         opcode,
  input  wire logic [4:0]   weight_index,
  input  wire logic [15:0]  sample,
  input  wire logic [39:0]  prior_out,
  output logic              emit_req,
  output sample_t           win [KTAPS],
  output sample_t           wts [KTAPS],
  output mac_req_t          req
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = ((CW > 11) ? CW : 11) + 2;
  localparam int HW = ((RW > 10) ? RW : 10) + 2;
  localparam int SB = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [EW-1:0] iw, ow, col;
  logic [HW-1:0] oh, row;
  logic          emit;
  sample_t       px;
  meta_t         meta;

  always_comb begin
    iw = EW'(cfg.in_width);
    if (iw < EW'(5)) iw = EW'(5);
    if (iw > EW'(MAX_WIDTH)) iw = EW'(MAX_WIDTH);
    ow = EW'(cfg.out_width);
    if (ow < EW'(1)) ow = EW'(1);
    if (ow > iw - EW'(4)) ow = iw - EW'(4);
    oh = HW'(cfg.out_height);
    if (oh < HW'(1)) oh = HW'(1);
    if (oh > HW'(MAX_HEIGHT - 4)) oh = HW'(MAX_HEIGHT - 4);
    col = EW'(col_count);
    if (col >= iw) col = '0;
    row = HW'(row_count);
    if (row >= oh + HW'(4)) row = '0;
    emit = (row >= HW'(4)) && (col >= EW'(4)) && ((row - HW'(4)) < oh) &&
           ((col - EW'(4)) < ow);
    meta.row   = 10'(row - HW'(4));
    meta.col   = 10'(col - EW'(4));
    meta.last  = ((row - HW'(4)) == oh - HW'(1)) && ((col - EW'(4)) == ow - EW'(1));
    meta.prior = prior_out;
    px = 16'($signed(sample[SB-1:0]));
    if (col + EW'(1) >= iw) begin
      col_count_next = '0;
      row_count_next = (row + HW'(1) >= oh + HW'(4)) ? '0 : RW'(row + HW'(1));
    end else begin
      col_count_next = CW'(col + EW'(1));
      row_count_next = RW'(row);
    end
  end

  assign emit_req = accept && (opcode == OP_PIXEL) && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept && (opcode == OP_PIXEL)) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage A: registered request plus line memory reads.
  logic          a_valid, a_pixel, a_emit;
  logic [4:0]    a_widx;
  sample_t       a_px;
  logic [1:0]    a_slot;
  meta_t         a_meta;
  sample_t       q [LINES];

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else a_valid <= accept;
    a_pixel <= (opcode == OP_PIXEL);
    a_emit  <= emit;
    a_widx  <= weight_index;
    a_px    <= px;
    a_slot  <= row[1:0];
    a_meta  <= meta;
  end

  for (genvar b = 0; b < LINES; b++) begin : g_bank
    sample_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept && (opcode == OP_PIXEL)) begin
        q[b] <= mem[col[CW-1:0]];
        if (row[1:0] == 2'(b)) mem[col[CW-1:0]] <= px;
      end
    end
  end

  // Stage B: shift window, apply weight loads in request order.
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      for (int k = 0; k < KTAPS; k++) begin
        win[k] <= '0;
        wts[k] <= '0;
      end
    end else begin
      req.valid <= a_valid && a_pixel && a_emit;
      if (a_valid && a_pixel) begin
        for (int i = 0; i < KSIZE; i++) begin
          for (int j = 0; j < KSIZE - 1; j++) win[i*KSIZE+j] <= win[i*KSIZE+j+1];
          win[i*KSIZE+KSIZE-1] <= (i < LINES) ? q[2'(a_slot + 2'(i))] : a_px;
        end
      end
      if (a_valid && !a_pixel && (a_widx < 5'(KTAPS))) wts[a_widx] <= a_px;
    end
  end

  always_ff @(posedge clk) req.meta <= a_meta;
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_mac.sv =====
// Back end: 25 products, adder tree, accumulate and saturate.
`timescale 1ns / 1ps
`default_nettype none
module c2d_mac import c2d_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire sample_t  win [KTAPS],
  input  wire sample_t  wts [KTAPS],
  input  wire mac_req_t req,
  output logic          res_valid,
  output result_t       res
);
  logic signed [31:0] prod [KTAPS];
  logic signed [34:0] rsum [KSIZE];
  logic signed [42:0] tot;
  logic               v1, v2, v3;
  meta_t              m1, m2, m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < KTAPS; k++) prod[k] <= win[k] * wts[k];
    m1 <= req.meta;
    for (int i = 0; i < KSIZE; i++) begin
      rsum[i] <= 35'(prod[i*KSIZE]) + 35'(prod[i*KSIZE+1]) + 35'(prod[i*KSIZE+2]) +
                 35'(prod[i*KSIZE+3]) + 35'(prod[i*KSIZE+4]);
    end
    m2 <= m1;
    tot <= 43'(m2.prior) + 43'(rsum[0]) + 43'(rsum[1]) + 43'(rsum[2]) +
           43'(rsum[3]) + 43'(rsum[4]);
    m3 <= m2;
    if (tot > 43'(VAL_MAX)) res.value <= VAL_MAX;
    else if (tot < 43'(VAL_MIN)) res.value <= VAL_MIN;
    else res.value <= tot[39:0];
    res.row  <= m3.row;
    res.col  <= m3.col;
    res.last <= m3.last;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_queue.sv =====
// Result queue between the arithmetic pipeline and the output side.
`timescale 1ns / 1ps
`default_nettype none
module c2d_queue import c2d_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr,
  input  wire result_t wr_data,
  input  wire logic    rd,
  output logic         empty,
  output result_t      rd_data
);
  localparam int PW = $clog2(QDEPTH);
  result_t       slots [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(wr) - (PW+1)'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/conv2d_5x5_valid_accumulate.sv =====
// Top level of the 5x5 valid-mode accumulating convolution block.
// Takes one request per cycle, weight loads and pixels alike, as long as the
// result side keeps popping; full rises only when the eight-entry result queue
// holds or has reserved eight results. A result reaches the queue head through
// line memory read, window shift, multiply, row sums, final add and clamp,
// then the queue write. Weight loads are applied in request order, so pixels
// accepted before a load use the old weights. Line memory is four banks of
// MAX_WIDTH samples, one per buffered row, needing no clearing.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_5x5_valid_accumulate import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode,
  input  wire logic [4:0]  weight_index,
  input  wire logic [15:0] sample,
  input  wire logic [39:0] prior_out,
  output logic             empty,
  input  wire logic        pop,
  output logic [39:0]      out_value,
  output logic [9:0]       out_row,
  output logic [9:0]       out_col,
  output logic             frame_last,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  localparam int CNTW = $clog2(QDEPTH + 1);

  cfg_t            cfg;
  logic            accept, emit_req, res_valid;
  logic [CNTW-1:0] credits;
  sample_t         win [KTAPS];
  sample_t         wts [KTAPS];
  mac_req_t        req;
  result_t         res, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width   <= 11'd64;
      cfg.out_width  <= 10'd60;
      cfg.out_height <= 10'd60;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_WIDTH:   cfg.in_width   <= cfg_data;
        REG_OUT_WIDTH:  cfg.out_width  <= cfg_data[9:0];
        REG_OUT_HEIGHT: cfg.out_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Reserve a queue slot for every result still in flight.
  assign full   = (credits == CNTW'(QDEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) credits <= '0;
    else credits <= credits + CNTW'(emit_req) - CNTW'(pop && !empty);
  end

  c2d_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk, .rst, .cfg, .accept, .opcode, .weight_index, .sample, .prior_out,
    .emit_req, .win, .wts, .req
  );

  c2d_mac u_mac (.clk, .rst, .win, .wts, .req, .res_valid, .res);

  c2d_queue u_queue (
    .clk, .rst, .wr(res_valid), .wr_data(res), .rd(pop), .empty, .rd_data(head)
  );

  assign out_value  = head.value;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign frame_last = head.last;
endmodule
`default_nettype wire

// ===== hw/rtl/c2d_checker.sv =====
// Port-level checker for the convolution block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_5x5_valid_accumulate_macros.svh"
module c2d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [39:0] out_value,
  input wire logic [9:0]  out_row,
  input wire logic [9:0]  out_col
);
  `C2D_ASSERT_NEXT(a_reset_clears, rst, empty && !full)
  `C2D_ASSERT_NEXT(a_head_holds, !rst && !empty && !pop, empty == 1'b0 && $stable(out_value))
  `C2D_ASSERT_NOW(a_coord_range, !empty, out_row <= 10'd1019 && out_col <= 10'd1019)
endmodule

bind conv2d_5x5_valid_accumulate c2d_checker u_chk (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the 5x5 valid-mode accumulating convolution block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import c2d_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = 1'b0;
  logic [4:0]  weight_index = '0;
  logic [15:0] sample = '0;
  logic [39:0] prior_out = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [39:0] out_value;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        frame_last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  conv2d_5x5_valid_accumulate u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .weight_index(weight_index), .sample(sample), .prior_out(prior_out),
    .empty(empty), .pop(pop), .out_value(out_value), .out_row(out_row),
    .out_col(out_col), .frame_last(frame_last), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state
  longint      kern_w [KTAPS];
  longint      win    [KTAPS];
  longint      lines  [LINES][DEF_MAX_WIDTH];
  int unsigned col_cnt, row_cnt;
  int unsigned reg_iw, reg_ow, reg_oh;

  result_t     pending_results[$];
  int          mismatches = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          recv_hold = 0;

  function automatic int unsigned eff_iw();
    int unsigned w;
    w = reg_iw;
    if (w < 5) w = 5;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_ow();
    int unsigned w;
    w = reg_ow;
    if (w < 1) w = 1;
    if (w > eff_iw() - 4) w = eff_iw() - 4;
    return w;
  endfunction

  function automatic int unsigned eff_oh();
    int unsigned h;
    h = reg_oh;
    if (h < 1) h = 1;
    if (h > DEF_MAX_HEIGHT - 4) h = DEF_MAX_HEIGHT - 4;
    return h;
  endfunction

  task automatic conv_predict(input logic op, input logic [4:0] idx,
                              input logic [15:0] smp, input logic [39:0] prior);
    int unsigned iw, ow, oh, col, row;
    longint px, acc;
    longint column [KSIZE];
    result_t r;
    if (op == OP_LOAD_WEIGHT) begin
      if (idx < KTAPS) kern_w[idx] = longint'($signed(smp));
      return;
    end
    iw = eff_iw();
    ow = eff_ow();
    oh = eff_oh();
    col = col_cnt;
    row = row_cnt;
    if (col >= iw) col = 0;
    if (row >= oh + 4) row = 0;
    px = longint'($signed(smp));
    for (int i = 0; i < LINES; i++) column[i] = lines[(row + i) % 4][col];
    column[LINES] = px;
    lines[row % 4][col] = px;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE - 1; j++) win[i*KSIZE+j] = win[i*KSIZE+j+1];
      win[i*KSIZE+KSIZE-1] = column[i];
    end
    if (row >= 4 && col >= 4 && row - 4 < oh && col - 4 < ow) begin
      acc = longint'($signed(prior));
      for (int i = 0; i < KTAPS; i++) acc += kern_w[i] * win[i];
      if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
      if (acc < longint'(VAL_MIN)) acc = longint'(VAL_MIN);
      r.value = acc[39:0];
      r.row   = 10'(row - 4);
      r.col   = 10'(col - 4);
      r.last  = (row - 4 == oh - 1) && (col - 4 == ow - 1);
      pending_results.push_back(r);
    end
    if (col + 1 >= iw) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= oh + 4) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  // One request: optional gap, then hold push until the block takes it.
  task automatic send_request(input logic op, input logic [4:0] idx,
                              input logic [15:0] smp, input logic [39:0] prior);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    opcode       <= op;
    weight_index <= idx;
    sample       <= smp;
    prior_out    <= prior;
    do @(posedge clk); while (full);
    conv_predict(op, idx, smp, prior);
  endtask

  // Drain outstanding results, then let the pipeline settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [10:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IN_WIDTH:   reg_iw = val;
      REG_OUT_WIDTH:  reg_ow = val[9:0];
      REG_OUT_HEIGHT: reg_oh = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [10:0] iw, input logic [10:0] ow,
                           input logic [10:0] oh);
    wait_drained();
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [39:0] pick_prior();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 40'($urandom_range(0, 2000)) - 40'd1000;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic load_kernel(input bit rand_w, input logic [15:0] val);
    for (int k = 0; k < KTAPS; k++)
      send_request(OP_LOAD_WEIGHT, 5'(k), rand_w ? pick_sample() : val, 40'($urandom));
  endtask

  // Stream one whole frame; noise_pct inserts weight loads between pixels.
  task automatic stream_frame(input int noise_pct, input bit fixed_px,
                              input logic [15:0] px_val, input logic [39:0] prior_val);
    int n;
    n = eff_iw() * (eff_oh() + 4);
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_request(OP_LOAD_WEIGHT, 5'($urandom), pick_sample(), pick_prior());
      send_request(OP_PIXEL, 5'($urandom), fixed_px ? px_val : pick_sample(),
                   fixed_px ? prior_val : pick_prior());
    end
  endtask

  // Reset sizes: five rows of 64; the next frame setup wraps the row count to zero.
  task automatic test_defaults();
    load_kernel(1'b1, '0);
    for (int p = 0; p < 64 * 5; p++)
      send_request(OP_PIXEL, 5'($urandom), pick_sample(), pick_prior());
  endtask

  task automatic test_saturation();
    set_frame(11'd5, 11'd1, 11'd1);
    load_kernel(1'b0, 16'h7FFF);
    stream_frame(0, 1'b1, 16'h7FFF, VAL_MAX);
    load_kernel(1'b0, 16'h8000);
    stream_frame(0, 1'b1, 16'h7FFF, VAL_MIN);
    stream_frame(0, 1'b1, 16'h8000, VAL_MIN);
    // ignored weight slots
    send_request(OP_LOAD_WEIGHT, 5'd25, 16'h1234, '0);
    send_request(OP_LOAD_WEIGHT, 5'd31, 16'h4321, '0);
    stream_frame(0, 1'b1, 16'h0001, '0);
  endtask

  task automatic test_out_of_range_regs();
    set_frame(11'd0, 11'd0, 11'd0);
    load_kernel(1'b1, '0);
    stream_frame(2, 1'b0, '0, '0);
    set_frame(11'd8, 11'd1023, 11'd2);
    stream_frame(0, 1'b0, '0, '0);
  endtask

  task automatic test_backpressure();
    set_frame(11'd8, 11'd4, 11'd4);
    send_idle = 1'b0;
    recv_hold = 300;
    stream_frame(0, 1'b0, '0, '0);
    send_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int count;
    count = 0;
    while (count < 900) begin
      set_frame(11'($urandom_range(5, 12)), 11'($urandom_range(0, 9)),
                11'($urandom_range(0, 4)));
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0) load_kernel(1'b1, '0);
      stream_frame(5, 1'b0, '0, '0);
      count += eff_iw() * (eff_oh() + 4);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Result side: random pop gaps, one long hold on request.
  initial begin : result_checker
    int gap;
    result_t e;
    @(negedge rst);
    forever begin
      gap = recv_idle ? $urandom_range(0, 12) : 0;
      if (recv_hold > 0) begin
        gap = recv_hold;
        recv_hold = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%0d row=%0d col=%0d last=%0b",
                   $signed(out_value), out_row, out_col, frame_last);
      end else begin
        e = pending_results.pop_front();
        if (out_value !== e.value || out_row !== e.row || out_col !== e.col ||
            frame_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
                     $signed(e.value), e.row, e.col, e.last,
                     $signed(out_value), out_row, out_col, frame_last);
        end
      end
    end
  end

  initial begin : run_limit
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : sequencer
    for (int k = 0; k < KTAPS; k++) begin
      kern_w[k] = 0;
      win[k] = 0;
    end
    for (int l = 0; l < LINES; l++)
      for (int c = 0; c < DEF_MAX_WIDTH; c++) lines[l][c] = 0;
    col_cnt = 0;
    row_cnt = 0;
    reg_iw = 64;
    reg_ow = 60;
    reg_oh = 60;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_saturation();
    test_backpressure();
    test_out_of_range_regs();
    test_random_frames();
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
